// ===== rtl/gpat_pkg.sv =====
// Package for the game port axis timer: widths, register map, opcodes and reset values.
// No dependencies; imported by game_port_axis_timer_top.
`timescale 1ns / 1ps

package gpat_pkg;

    // Default width of elapsed time and of the axis result fields.
    localparam int TIME_BITS_DEF = 20;

    // Fixed widths of the configuration registers.
    localparam int TMO_BITS   = 20;
    localparam int SHIFT_BITS = 6;

    // Largest shift that a correction register holds.
    localparam logic [SHIFT_BITS-1:0] SHIFT_CAP = 6'd32;

    // Reset value of both timeout registers.
    localparam logic [TMO_BITS-1:0] TMO_RESET = 20'd4096;

    // APB address width and register indexes (byte address is 4 * index).
    localparam int ADDR_BITS = 5;
    localparam int IDX_BITS  = 3;

    typedef enum logic [IDX_BITS-1:0] {
        REG_SHIFT_X0  = 3'd0,
        REG_SHIFT_Y0  = 3'd1,
        REG_SHIFT_X1  = 3'd2,
        REG_SHIFT_Y1  = 3'd3,
        REG_TIMEOUT0  = 3'd4,
        REG_TIMEOUT1  = 3'd5
    } reg_idx_t;

    // Input transaction kind, carried on s_tuser.
    typedef enum logic {
        OP_TRIGGER = 1'b0,
        OP_SAMPLE  = 1'b1
    } op_t;

    // Input payload layout.
    localparam int IN_DATA_BITS = 16;

endpackage

// ===== rtl/game_port_axis_timer_top.sv =====
// Top level of the game port axis timer: stream input and output, APB register port.
// Depends on gpat_pkg for widths, register indexes, opcodes and reset values.
`timescale 1ns / 1ps

// A run's result is registered in the output register, or in the skid register while the
// output register is full and not taken, when its ending sample transaction is accepted.
// Throughput: one input transaction per clock while the skid register is empty; a two-entry
// output buffer (output plus skid register) keeps s_tready high while one result waits on m_tready.
// Reset: synchronous, active low; clears the run state, empties the output buffer,
// sets the correction registers to 0 and both timeout registers to 4096.
module game_port_axis_timer_top
    import gpat_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, from bit 0 up: axis_mask[3:0], stick_select[4], port_bits[12:5], zeros.
    input  logic [IN_DATA_BITS-1:0] s_tdata,
    // s_tuser: op (0 trigger, 1 sample).
    input  logic                  s_tuser,

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0 up: axis_x0, axis_y0, axis_x1, axis_y1 (TIME_BITS each),
    // buttons_stick0[4], buttons_stick1[2], timed_out[1], present_axes[4],
    // full_sticks[2], partial_stick[1], zeros up to a whole byte.
    output logic [((4*TIME_BITS+14+7)/8)*8-1:0] m_tdata,

    // APB register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int RES_BITS  = 4*TIME_BITS + 14;
    localparam int OUT_BITS  = ((RES_BITS + 7) / 8) * 8;
    localparam int CMP_BITS  = (TIME_BITS > TMO_BITS) ? TIME_BITS : TMO_BITS;

    // ------------------------------------------------------------------
    // Configuration registers. Shifts are clamped to 32 when written.
    // ------------------------------------------------------------------
    logic [SHIFT_BITS-1:0] shift_reg [4];
    logic [TMO_BITS-1:0]   timeout_reg [2];

    logic                  cfg_write;
    reg_idx_t              cfg_idx;
    logic [SHIFT_BITS-1:0] shift_wr;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign shift_wr  = (pwdata[SHIFT_BITS-1:0] > SHIFT_CAP) ? SHIFT_CAP
                                                            : pwdata[SHIFT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                shift_reg[i] <= '0;
            end
            timeout_reg[0] <= TMO_RESET;
            timeout_reg[1] <= TMO_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_SHIFT_X0: shift_reg[0]   <= shift_wr;
                REG_SHIFT_Y0: shift_reg[1]   <= shift_wr;
                REG_SHIFT_X1: shift_reg[2]   <= shift_wr;
                REG_SHIFT_Y1: shift_reg[3]   <= shift_wr;
                REG_TIMEOUT0: timeout_reg[0] <= pwdata[TMO_BITS-1:0];
                REG_TIMEOUT1: timeout_reg[1] <= pwdata[TMO_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register readback; addresses past the map read as zero.
    always_comb begin
        case (cfg_idx)
            REG_SHIFT_X0: prdata = 32'(shift_reg[0]);
            REG_SHIFT_Y0: prdata = 32'(shift_reg[1]);
            REG_SHIFT_X1: prdata = 32'(shift_reg[2]);
            REG_SHIFT_Y1: prdata = 32'(shift_reg[3]);
            REG_TIMEOUT0: prdata = 32'(timeout_reg[0]);
            REG_TIMEOUT1: prdata = 32'(timeout_reg[1]);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input decode.
    // ------------------------------------------------------------------
    logic       in_accept;
    op_t        in_op;
    logic [3:0] in_mask;
    logic       in_sel;
    logic [7:0] in_port;

    assign in_accept = s_tvalid && s_tready;
    assign in_op     = op_t'(s_tuser);
    assign in_mask   = s_tdata[3:0];
    assign in_sel    = s_tdata[4];
    assign in_port   = s_tdata[12:5];

    // ------------------------------------------------------------------
    // Run state and its update.
    // ------------------------------------------------------------------
    logic                 measuring_reg, measuring_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] capture_reg [4];
    logic [TIME_BITS-1:0] capture_next [4];
    logic [3:0]           mask_reg, mask_next;
    logic [TMO_BITS-1:0]  timeout_act_reg, timeout_act_next;

    logic                 waiting;     // a waited-on axis is still high
    logic                 below_limit; // elapsed time may still advance
    logic                 end_run;     // this sample closes the run
    logic [TIME_BITS-1:0] elapsed_inc;

    assign waiting     = (in_port[3:0] & mask_reg) != 4'd0;
    assign below_limit = (CMP_BITS'(elapsed_reg) < CMP_BITS'(timeout_act_reg))
                         && (elapsed_reg != {TIME_BITS{1'b1}});
    assign elapsed_inc = elapsed_reg + 1'b1;
    assign end_run     = in_accept && (in_op == OP_SAMPLE) && measuring_reg
                         && !(waiting && below_limit);

    always_comb begin
        measuring_next   = measuring_reg;
        elapsed_next     = elapsed_reg;
        mask_next        = mask_reg;
        timeout_act_next = timeout_act_reg;
        for (int i = 0; i < 4; i++) begin
            capture_next[i] = capture_reg[i];
        end
        if (in_accept) begin
            case (in_op)
                OP_TRIGGER: begin
                    // A trigger always restarts; a run in progress is dropped.
                    measuring_next   = 1'b1;
                    elapsed_next     = '0;
                    mask_next        = in_mask;
                    timeout_act_next = timeout_reg[in_sel];
                    for (int i = 0; i < 4; i++) begin
                        capture_next[i] = '0;
                    end
                end
                OP_SAMPLE: begin
                    if (measuring_reg) begin
                        if (waiting && below_limit) begin
                            // Every axis still high, waited on or not, takes the new time.
                            elapsed_next = elapsed_inc;
                            for (int i = 0; i < 4; i++) begin
                                if (in_port[i]) begin
                                    capture_next[i] = elapsed_inc;
                                end
                            end
                        end else begin
                            measuring_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            measuring_reg   <= 1'b0;
            elapsed_reg     <= '0;
            mask_reg        <= '0;
            timeout_act_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                capture_reg[i] <= '0;
            end
        end else begin
            measuring_reg   <= measuring_next;
            elapsed_reg     <= elapsed_next;
            mask_reg        <= mask_next;
            timeout_act_reg <= timeout_act_next;
            for (int i = 0; i < 4; i++) begin
                capture_reg[i] <= capture_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result assembly from the captures and the ending sample's port byte.
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] axis_time [4];
    logic [3:0]           present;
    logic [3:0]           buttons;
    logic [1:0]           full_cnt;
    logic                 partial;
    logic [OUT_BITS-1:0]  result;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            // A shift of 32 or more clears the field.
            axis_time[i] = capture_reg[i] >> shift_reg[i];
        end
    end

    assign present  = ~in_port[3:0];
    assign buttons  = ~in_port[7:4];
    assign full_cnt = 2'((present[1:0] == 2'b11)) + 2'((present[3:2] == 2'b11));
    assign partial  = (present[0] ^ present[1]) || (present[2] ^ present[3]);

    assign result = OUT_BITS'({partial, full_cnt, present, waiting, buttons[3:2], buttons,
                               axis_time[3], axis_time[2], axis_time[1], axis_time[0]});

    // ------------------------------------------------------------------
    // Output register with a skid register behind it.
    // ------------------------------------------------------------------
    logic                out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [OUT_BITS-1:0] skid_data_reg, skid_data_next;
    logic                out_pop;

    assign out_pop  = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = end_run;
                skid_data_next  = result;
            end else begin
                out_valid_next = end_run;
                out_data_next  = result;
            end
        end else if (end_run) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The skid register only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // Elapsed time never passes the timeout latched for the run.
    a_elapsed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        measuring_reg |-> (CMP_BITS'(elapsed_reg) <= CMP_BITS'(timeout_act_reg)))
        else $error("elapsed time beyond the active timeout");

    // A run that ends leaves the block idle and a result buffered.
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        end_run |=> (!measuring_reg && out_valid_reg))
        else $error("run ended without going idle or buffering a result");

    // An accepted trigger always starts a run from zero.
    a_trigger_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_op == OP_TRIGGER)) |=> (measuring_reg && (elapsed_reg == '0)))
        else $error("trigger did not start a fresh run");

endmodule
